// ===== sv/clnq_pkg.sv =====
// Shared types, constants and lookup functions for the character LCD nibble queue writer.
`timescale 1ns / 1ps
`default_nettype none
package clnq_pkg;

	localparam int FIFO_DEPTH_DEF = 128;

	// Register select bit of a queued word: set for display data, clear for commands.
	localparam logic RS_DATA = 1'b1;
	localparam logic RS_CMD  = 1'b0;

	localparam logic [7:0] ASCII_ZERO    = 8'd48;
	localparam logic [7:0] ASCII_LOWER_A = 8'd97;
	localparam logic [7:0] CURSOR_CMD    = 8'h80;

	typedef enum logic [2:0] {
		K_CHAR   = 3'd0,
		K_CMD    = 3'd1,
		K_HEX8   = 3'd2,
		K_HEX16  = 3'd3,
		K_HEX32  = 3'd4,
		K_CURSOR = 3'd5,
		K_INIT   = 3'd6,
		K_TICK   = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		GM_RAW  = 2'd0,
		GM_HEX  = 2'd1,
		GM_INIT = 2'd2
	} gen_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_PUSH = 2'd1,
		ST_POP  = 2'd2
	} state_t;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [4:0] word;
	} gen_word_t;

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		unique case (r)
			2'd0: b = 8'h00;
			2'd1: b = 8'h40;
			2'd2: b = 8'h14;
			2'd3: b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [3:0] init_word(input logic [3:0] i);
		logic [3:0] w;
		unique case (i)
			4'd0:  w = 4'h3;
			4'd1:  w = 4'h3;
			4'd2:  w = 4'h3;
			4'd3:  w = 4'h2;
			4'd4:  w = 4'h2;
			4'd5:  w = 4'ha;
			4'd6:  w = 4'h0;
			4'd7:  w = 4'h8;
			4'd8:  w = 4'h0;
			4'd9:  w = 4'h1;
			4'd10: w = 4'h0;
			4'd11: w = 4'hc;
			4'd12: w = 4'h0;
			4'd13: w = 4'h6;
			4'd14: w = 4'h0;
			4'd15: w = 4'h2;
			default: w = 4'h0;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] hex_ascii(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = ASCII_ZERO + {4'b0, d};
		end else begin
			c = ASCII_LOWER_A - 8'd10 + {4'b0, d};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== sv/char_lcd_nibble_queue_writer_core.sv =====
// Top level of the character LCD nibble queue writer: command FSM, FIFO pointers and result.
`timescale 1ns / 1ps
`default_nettype none
// A push item (char, command, hex, cursor or init) is split into 5-bit LCD words that are
// written into the nibble FIFO one per cycle through its single write port, after the item
// has been loaded into the nibble sequencer. A tick does one registered RAM read when the FIFO
// holds a word and no read when it is empty. Each item gives exactly one result beat, shown
// for one cycle with done high; the receiver cannot stall it, and busy is low again in that
// same cycle. Words that find the FIFO full are dropped and flagged in the result. The FIFO
// store has no reset; only words written since reset are ever read.
module char_lcd_nibble_queue_writer_core #(
	parameter int FIFO_DEPTH = clnq_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] value,
	input  wire logic [7:0]  column,
	input  wire logic [1:0]  row,
	output      logic        done,
	output      logic [4:0]  pins,
	output      logic        strobe_res,
	output      logic        dropped,
	output      logic [7:0]  fill
);
	import clnq_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	state_t state_q, state_d;

	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          done_q, drop_q, strobe_q;
	logic [4:0]    pins_q;
	logic [4:0]    rdata;
	logic [CW+7:0] cnt_ext;

	gen_word_t gen;
	kind_t     kind_in;
	logic      accept, is_tick, full, empty;
	logic      gen_load, ram_we, ram_re, drop_set, done_d;

	assign kind_in = kind_t'(kind);
	assign accept  = start && !busy;
	assign is_tick = (kind_in == K_TICK);
	assign full    = (cnt_q == CW'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);

	clnq_nib_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (gen_load),
		.kind   (kind_in),
		.value  (value),
		.column (column),
		.row    (row),
		.nib    (gen)
	);

	clnq_ram #(
		.WIDTH (5),
		.DEPTH (FIFO_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (gen.word),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!is_tick) begin
						state_d = ST_PUSH;
					end else if (!empty) begin
						state_d = ST_POP;
					end
				end
			end
			ST_PUSH: begin
				if (gen.valid && gen.last) begin
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		gen_load = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		drop_set = 1'b0;
		done_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				gen_load = accept && !is_tick;
				ram_re   = accept && is_tick && !empty;
				done_d   = accept && is_tick && empty;
			end
			ST_PUSH: begin
				ram_we   = gen.valid && !full;
				drop_set = gen.valid && full;
				done_d   = gen.valid && gen.last;
			end
			ST_POP: begin
				done_d = 1'b1;
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			drop_q   <= 1'b0;
			strobe_q <= 1'b0;
			pins_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			// Writes happen only while pushing and reads only on a tick, so never together.
			if (ram_we) begin
				wr_ptr_q <= (wr_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				cnt_q    <= cnt_q + 1'b1;
			end else if (ram_re) begin
				rd_ptr_q <= (rd_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				cnt_q    <= cnt_q - 1'b1;
			end
			if (accept) begin
				drop_q   <= 1'b0;
				strobe_q <= 1'b0;
				pins_q   <= '0;
			end else begin
				if (drop_set) begin
					drop_q <= 1'b1;
				end
				if (state_q == ST_POP) begin
					strobe_q <= 1'b1;
					pins_q   <= rdata;
				end
			end
		end
	end

	assign cnt_ext    = {8'b0, cnt_q};
	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign pins       = pins_q;
	assign strobe_res = strobe_q;
	assign dropped    = drop_q;
	assign fill       = cnt_ext[7:0];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(FIFO_DEPTH))
		else $error("FIFO count exceeds depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !full)
		else $error("FIFO written while full");

	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |=> (done && strobe_res && !dropped))
		else $error("pop did not give a strobed result");

	a_drop_not_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dropped) |-> !strobe_res)
		else $error("drop flag on a tick result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still working");

endmodule
`default_nettype wire

// ===== sv/clnq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module clnq_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/clnq_nib_gen.sv =====
// Nibble sequencer: shifts a push item out as 5-bit LCD words, one word per cycle.
`timescale 1ns / 1ps
`default_nettype none
module clnq_nib_gen (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire clnq_pkg::kind_t    kind,
	input  wire logic [31:0]        value,
	input  wire logic [7:0]         column,
	input  wire logic [1:0]         row,
	output      clnq_pkg::gen_word_t nib
);
	import clnq_pkg::*;

	logic      act_q;
	logic [3:0] idx_q;
	logic [3:0] last_q;
	gen_mode_t mode_q;
	logic      rs_q;
	logic [31:0] sh_q;

	logic [31:0] ld_sh;
	logic [3:0]  ld_last;
	gen_mode_t   ld_mode;
	logic        ld_rs;
	logic [7:0]  cursor_addr;
	logic [7:0]  ch;
	logic [3:0]  nib_val;

	assign cursor_addr = row_base(row) + column + CURSOR_CMD;

	always_comb begin
		ld_sh   = {value[7:0], 24'b0};
		ld_last = 4'd1;
		ld_mode = GM_RAW;
		ld_rs   = RS_CMD;
		unique case (kind)
			K_CHAR: begin
				ld_rs = RS_DATA;
			end
			K_CMD: begin
				ld_rs = RS_CMD;
			end
			K_HEX8: begin
				ld_mode = GM_HEX;
				ld_rs   = RS_DATA;
				ld_last = 4'd3;
			end
			K_HEX16: begin
				ld_sh   = {value[15:0], 16'b0};
				ld_mode = GM_HEX;
				ld_rs   = RS_DATA;
				ld_last = 4'd7;
			end
			K_HEX32: begin
				ld_sh   = value;
				ld_mode = GM_HEX;
				ld_rs   = RS_DATA;
				ld_last = 4'd15;
			end
			K_CURSOR: begin
				ld_sh = {cursor_addr, 24'b0};
			end
			K_INIT: begin
				ld_mode = GM_INIT;
				ld_last = 4'd15;
			end
			K_TICK: begin
				ld_rs = RS_CMD;
			end
			default: begin
				ld_rs = RS_CMD;
			end
		endcase
	end

	// Each digit gives two words: the high nibble on an even index, the low one on an odd.
	always_comb begin
		ch = hex_ascii(sh_q[31:28]);
		unique case (mode_q)
			GM_RAW:  nib_val = idx_q[0] ? sh_q[27:24] : sh_q[31:28];
			GM_HEX:  nib_val = idx_q[0] ? ch[3:0] : ch[7:4];
			GM_INIT: nib_val = init_word(idx_q);
			default: nib_val = 4'h0;
		endcase
	end

	assign nib.valid = act_q;
	assign nib.last  = (idx_q == last_q);
	assign nib.word  = {rs_q, nib_val};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			idx_q  <= '0;
			last_q <= '0;
			mode_q <= GM_RAW;
			rs_q   <= RS_CMD;
		end else if (load) begin
			act_q  <= 1'b1;
			idx_q  <= '0;
			last_q <= ld_last;
			mode_q <= ld_mode;
			rs_q   <= ld_rs;
		end else if (act_q) begin
			idx_q <= idx_q + 4'd1;
			if (idx_q == last_q) begin
				act_q <= 1'b0;
			end
		end
	end

	// The digit register moves on by one nibble once both words of a digit have gone out.
	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= ld_sh;
		end else if (act_q && idx_q[0]) begin
			sh_q <= {sh_q[27:0], 4'b0};
		end
	end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the character LCD nibble queue writer core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import clnq_pkg::*;

	localparam int WORD_SLOTS   = FIFO_DEPTH_DEF;
	localparam int ITEM_TARGET  = 700;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_WAIT  = 40;
	localparam int PRINT_LIMIT  = 30;

	// DDRAM start address of each display line, line 0 in the low byte.
	localparam logic [31:0] LINE_START_ADDRS = {8'h54, 8'h14, 8'h40, 8'h00};
	// Power-on command nibbles, first one in the top nibble.
	localparam logic [63:0] POWER_ON_NIBBLES = 64'h3332_2a08_010c_0602;

	typedef struct {
		kind_t       kind;
		logic [31:0] value;
		logic [7:0]  column;
		logic [1:0]  row;
		int          idle_pct;
	} lcd_item_t;

	typedef struct packed {
		logic [4:0] pins;
		logic       strobe;
		logic       dropped;
		logic [7:0] fill;
	} pin_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  kind = '0;
	logic [31:0] value = '0;
	logic [7:0]  column = '0;
	logic [1:0]  row = '0;
	wire         busy;
	wire         done;
	wire  [4:0]  pins;
	wire         strobe_res;
	wire         dropped;
	wire  [7:0]  fill;

	char_lcd_nibble_queue_writer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.value      (value),
		.column     (column),
		.row        (row),
		.done       (done),
		.pins       (pins),
		.strobe_res (strobe_res),
		.dropped    (dropped),
		.fill       (fill)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	lcd_item_t lcd_commands[$];
	pin_beat_t expected_pin_beats[$];

	// Shadow of the word FIFO.
	logic [4:0] word_shadow [WORD_SLOTS];
	int         shadow_rd;
	int         shadow_wr;
	int         shadow_count;
	logic       push_lost;

	int mismatches;
	int cycle_count;
	int items_sent;
	int beats_checked;
	int drop_beats;
	int empty_ticks;
	int full_seen;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic enqueue_word(input logic [4:0] w);
		if (shadow_count >= WORD_SLOTS) begin
			push_lost = 1'b1;
		end else begin
			word_shadow[shadow_wr] = w;
			shadow_wr = (shadow_wr + 1) % WORD_SLOTS;
			shadow_count++;
		end
	endtask

	task automatic enqueue_byte(input logic [7:0] b, input logic rs);
		enqueue_word({rs, b[7:4]});
		enqueue_word({rs, b[3:0]});
	endtask

	task automatic enqueue_hex(input logic [31:0] v, input int digits);
		logic [3:0] d;
		for (int i = digits - 1; i >= 0; i--) begin
			d = v[4 * i +: 4];
			enqueue_byte(d < 4'd10 ? ASCII_ZERO + d : ASCII_LOWER_A - 8'd10 + d, RS_DATA);
		end
	endtask

	// Applies one accepted item to the FIFO shadow and gives the beat it must produce.
	task automatic advance_lcd_queue(input lcd_item_t it, output pin_beat_t beat);
		logic [7:0] addr;
		beat = '0;
		push_lost = 1'b0;
		case (it.kind)
			K_CHAR: enqueue_byte(it.value[7:0], RS_DATA);
			K_CMD: enqueue_byte(it.value[7:0], RS_CMD);
			K_HEX8: enqueue_hex({24'b0, it.value[7:0]}, 2);
			K_HEX16: enqueue_hex({16'b0, it.value[15:0]}, 4);
			K_HEX32: enqueue_hex(it.value, 8);
			K_CURSOR: begin
				addr = LINE_START_ADDRS[8 * it.row +: 8] + it.column + CURSOR_CMD;
				enqueue_byte(addr, RS_CMD);
			end
			K_INIT: begin
				for (int i = 0; i < 16; i++)
					enqueue_word({RS_CMD, POWER_ON_NIBBLES[63 - 4 * i -: 4]});
			end
			default: begin
				if (shadow_count > 0) begin
					beat.pins = word_shadow[shadow_rd];
					beat.strobe = 1'b1;
					shadow_rd = (shadow_rd + 1) % WORD_SLOTS;
					shadow_count--;
				end
			end
		endcase
		beat.dropped = push_lost;
		beat.fill = shadow_count[7:0];
	endtask

	function automatic lcd_item_t make_item(input kind_t k, input logic [31:0] v,
			input logic [7:0] c, input logic [1:0] r, input int idle);
		lcd_item_t it;
		it.kind = k;
		it.value = v;
		it.column = c;
		it.row = r;
		it.idle_pct = idle;
		return it;
	endfunction

	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return 32'hffff_ffff;
		if (sel == 1)
			return 32'h0;
		return $urandom;
	endfunction

	// Random part goes through stretches with no gaps, heavy gaps, light gaps, then none.
	function automatic int gap_for(input int idx);
		if (idx < 200)
			return 0;
		if (idx < 380)
			return 78;
		if (idx < 540)
			return 20;
		return 0;
	endfunction

	// Driver: the head of lcd_commands is the item on the ports until it is taken.
	always @(posedge clk) begin
		pin_beat_t beat;
		if (arst_n) begin
			if (start && !busy) begin
				advance_lcd_queue(lcd_commands[0], beat);
				expected_pin_beats.push_back(beat);
				if (beat.fill == 8'(WORD_SLOTS))
					full_seen++;
				void'(lcd_commands.pop_front());
				items_sent++;
			end
			if (!(start && busy)) begin
				if (lcd_commands.size() > 0 && $urandom_range(99) >= lcd_commands[0].idle_pct) begin
					start <= 1'b1;
					kind <= lcd_commands[0].kind;
					value <= lcd_commands[0].value;
					column <= lcd_commands[0].column;
					row <= lcd_commands[0].row;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done beat is checked against the oldest prediction.
	always @(posedge clk) begin
		pin_beat_t want;
		if (arst_n && done) begin
			if (expected_pin_beats.size() == 0) begin
				report_mismatch($sformatf("beat with nothing pending: pins=%h strobe=%b fill=%0d",
					pins, strobe_res, fill));
			end else begin
				want = expected_pin_beats.pop_front();
				beats_checked++;
				if (want.dropped)
					drop_beats++;
				if (want.fill == 0 && !want.strobe && !want.dropped)
					empty_ticks++;
				if (pins !== want.pins)
					report_mismatch($sformatf("pins %h, want %h", pins, want.pins));
				if (strobe_res !== want.strobe)
					report_mismatch($sformatf("strobe_res %b, want %b", strobe_res, want.strobe));
				if (dropped !== want.dropped)
					report_mismatch($sformatf("dropped %b, want %b", dropped, want.dropped));
				if (fill !== want.fill)
					report_mismatch($sformatf("fill %0d, want %0d", fill, want.fill));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d items and %0d beats outstanding",
				lcd_commands.size(), expected_pin_beats.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int idx;
		int seg_mode;
		int seg_len;
		int tick_pct;
		int random_target;
		kind_t k;

		mismatches = 0;
		cycle_count = 0;
		items_sent = 0;
		beats_checked = 0;
		drop_beats = 0;
		empty_ticks = 0;
		full_seen = 0;
		shadow_rd = 0;
		shadow_wr = 0;
		shadow_count = 0;
		push_lost = 1'b0;

		// Directed: empty tick, field extremes, every kind, cursor wrap on each line.
		lcd_commands.push_back(make_item(K_TICK, 32'h0, 8'h00, 2'd0, 0));
		lcd_commands.push_back(make_item(K_CHAR, 32'h0000_0000, 8'h00, 2'd0, 0));
		lcd_commands.push_back(make_item(K_TICK, 32'hffff_ffff, 8'hff, 2'd3, 0));
		lcd_commands.push_back(make_item(K_CHAR, 32'hffff_ffff, 8'hff, 2'd3, 0));
		lcd_commands.push_back(make_item(K_CMD, 32'h0000_00a5, 8'h00, 2'd0, 0));
		lcd_commands.push_back(make_item(K_CMD, 32'hffff_ff5a, 8'h00, 2'd0, 0));
		lcd_commands.push_back(make_item(K_HEX8, 32'h0000_0000, 8'h00, 2'd0, 0));
		lcd_commands.push_back(make_item(K_HEX8, 32'hffff_ffff, 8'h00, 2'd0, 0));
		lcd_commands.push_back(make_item(K_HEX16, 32'hffff_09af, 8'h00, 2'd0, 0));
		lcd_commands.push_back(make_item(K_HEX32, 32'h0123_4567, 8'h00, 2'd0, 0));
		lcd_commands.push_back(make_item(K_HEX32, 32'h89ab_cdef, 8'h00, 2'd0, 0));
		for (int r = 0; r < 4; r++) begin
			lcd_commands.push_back(make_item(K_CURSOR, 32'h0, 8'h00, 2'(r), 0));
			lcd_commands.push_back(make_item(K_CURSOR, 32'h0, 8'hff, 2'(r), 0));
		end
		lcd_commands.push_back(make_item(K_INIT, 32'hffff_ffff, 8'hff, 2'd3, 0));
		for (int i = 0; i < 5; i++)
			lcd_commands.push_back(make_item(K_TICK, $urandom, 8'(i), 2'(i), 0));

		// Random: fill bursts that overflow the FIFO, long drains that empty it, and mixes.
		random_target = ITEM_TARGET - lcd_commands.size();
		idx = 0;
		while (idx < random_target) begin
			seg_mode = $urandom_range(2);
			case (seg_mode)
				0: begin
					seg_len = $urandom_range(30, 50);
					tick_pct = 20;
				end
				1: begin
					seg_len = $urandom_range(100, 170);
					tick_pct = 92;
				end
				default: begin
					seg_len = $urandom_range(30, 60);
					tick_pct = 85;
				end
			endcase
			for (int j = 0; j < seg_len && idx < random_target; j++) begin
				if ($urandom_range(99) < tick_pct)
					k = K_TICK;
				else
					k = kind_t'($urandom_range(6));
				lcd_commands.push_back(make_item(k, pick_value(),
					$urandom_range(3) == 0 ? 8'hff : 8'($urandom_range(255)),
					2'($urandom_range(3)), gap_for(idx)));
				idx++;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (lcd_commands.size() != 0 || expected_pin_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);

		$display("%0d items driven, %0d beats checked, %0d mismatches", items_sent,
			beats_checked, mismatches);
		$display("coverage: %0d beats with lost words, %0d ticks on empty, %0d at full",
			drop_beats, empty_ticks, full_seen);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
